@@ rtl/assert_macros.svh @@
// Assertion macros used by the histogram controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CBH_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define CBH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cbh_pkg.sv @@
// Shared types and constants for the cumulative bucket histogram.
package cbh_pkg;

    localparam int MAX_BOUNDS_DEF  = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 64;
    localparam int SUM_W     = 64;
    localparam int CFG_BIU_W = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register index, taken from paddr[PADDR_W-1:2].
    localparam logic [PADDR_W-3:0] REG_BOUNDS_IN_USE = '0;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD     = 2'd0,
        KIND_OBSERVE  = 2'd1,
        KIND_SNAPSHOT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OBS_CNT,
        ST_OBS_RD,
        ST_OBS_WR,
        ST_SNAP_RD,
        ST_SNAP_ACC
    } state_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_OBS_OK,
        EMIT_OBS_ERR,
        EMIT_SNAP_MID,
        EMIT_SNAP_LAST
    } emit_t;

    typedef struct packed {
        logic  load_bound;   // write boundary slot from the input beat
        logic  capture;      // latch observe value and compare bank
        logic  snap_init;    // clear snapshot index and running total
        logic  cnt_idx;      // turn compare vector into bucket index
        logic  rd_obs;       // read count memory at bucket index
        logic  rd_snap;      // read count memory at snapshot index
        logic  cnt_wr;       // write incremented count, update sum
        logic  snap_step;    // fold read count into total, advance index
        emit_t emit;         // load output register
    } cmd_t;

    typedef struct packed {
        logic unsorted;
        logic snap_in_range;
        logic snap_at_end;
    } sts_t;

endpackage

@@ rtl/cbh_ctrl.sv @@
// Controller state machine and output-valid register of the histogram.
`include "assert_macros.svh"

module cbh_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic [cbh_pkg::KIND_W-1:0]  s_kind,
    output logic                        s_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  cbh_pkg::sts_t               sts_i,
    output cbh_pkg::cmd_t               cmd_o
);
    import cbh_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        cmd_o.emit = EMIT_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (kind_t'(s_kind))
                        KIND_LOAD: begin
                            cmd_o.load_bound = 1'b1;
                        end
                        KIND_OBSERVE: begin
                            cmd_o.capture = 1'b1;
                            state_next    = ST_OBS_CNT;
                        end
                        KIND_SNAPSHOT: begin
                            cmd_o.snap_init = 1'b1;
                            state_next      = ST_SNAP_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_OBS_CNT: begin
                cmd_o.cnt_idx = 1'b1;
                state_next    = ST_OBS_RD;
            end
            ST_OBS_RD: begin
                if (sts_i.unsorted) begin
                    if (out_free) begin
                        cmd_o.emit = EMIT_OBS_ERR;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd_o.rd_obs = 1'b1;
                    state_next   = ST_OBS_WR;
                end
            end
            ST_OBS_WR: begin
                if (out_free) begin
                    cmd_o.cnt_wr = 1'b1;
                    cmd_o.emit   = EMIT_OBS_OK;
                    state_next   = ST_IDLE;
                end
            end
            ST_SNAP_RD: begin
                cmd_o.rd_snap = 1'b1;
                state_next    = ST_SNAP_ACC;
            end
            ST_SNAP_ACC: begin
                priority if (sts_i.snap_at_end) begin
                    if (out_free) begin
                        cmd_o.emit = EMIT_SNAP_LAST;
                        state_next = ST_IDLE;
                    end
                end else if (sts_i.snap_in_range) begin
                    if (out_free) begin
                        cmd_o.emit      = EMIT_SNAP_MID;
                        cmd_o.snap_step = 1'b1;
                        state_next      = ST_SNAP_RD;
                    end
                end else begin
                    // bucket above the in-use count: fold in silently
                    cmd_o.snap_step = 1'b1;
                    state_next      = ST_SNAP_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd_o.emit != EMIT_NONE) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    `CBH_ASSERT_IMPLY(a_emit_slot_free, aclk, aresetn, cmd_o.emit != EMIT_NONE, out_free, "result overwrote a waiting beat")
    `CBH_ASSERT_IMPLY(a_wr_with_result, aclk, aresetn, cmd_o.cnt_wr, cmd_o.emit == EMIT_OBS_OK, "count write without observe result")
    `CBH_ASSERT_NEXT(a_snap_starts, aclk, aresetn, s_valid && s_ready && s_kind == KIND_SNAPSHOT, state_reg == ST_SNAP_RD, "snapshot did not start")

endmodule

@@ rtl/cbh_datapath.sv @@
// Datapath: boundary bank, compare bank, count memory, sum and output register.
module cbh_datapath #(
    parameter int MAX_BOUNDS  = cbh_pkg::MAX_BOUNDS_DEF,
    parameter int VALUE_WIDTH = cbh_pkg::VALUE_WIDTH_DEF,
    parameter int IDX_W       = $clog2(MAX_BOUNDS + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [IDX_W-1:0]                  n_i,
    input  logic [cbh_pkg::SLOT_W-1:0]        s_slot,
    input  logic signed [VALUE_WIDTH-1:0]     s_value,
    input  cbh_pkg::cmd_t                     cmd_i,
    output cbh_pkg::sts_t                     sts_o,
    output logic                              m_status,
    output logic [IDX_W-1:0]                  m_bucket_index,
    output logic [cbh_pkg::COUNT_W-1:0]       m_cum_count,
    output logic signed [VALUE_WIDTH-1:0]     m_bucket_bound,
    output logic                              m_is_infinite,
    output logic signed [cbh_pkg::SUM_W-1:0]  m_total_sum,
    output logic                              m_last
);
    import cbh_pkg::*;

    localparam int BND_AW = (MAX_BOUNDS > 1) ? $clog2(MAX_BOUNDS) : 1;
    localparam int DEPTH  = MAX_BOUNDS + 1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // boundary bank: undefined until loaded
    logic signed [VALUE_WIDTH-1:0] bound_reg [MAX_BOUNDS];

    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic [MAX_BOUNDS-1:0]         lt_reg, lt_next;
    logic                          unsorted_reg, unsorted_next;
    logic [IDX_W-1:0]              bucket_reg;

    // count memory with reset-cleared valid bits
    logic [COUNT_W-1:0] cnt_mem [DEPTH];
    logic [DEPTH-1:0]   cnt_vld_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [COUNT_W-1:0] rd_eff, cnt_inc;

    logic [IDX_W-1:0]   snap_idx_reg;
    logic [COUNT_W-1:0] cum_reg, cum_next;
    logic [COUNT_W:0]   cum_sum;

    logic signed [SUM_W-1:0] sum_reg, sum_add, sum_raw, sum_sat;
    logic                    sum_ovf;

    // compare bank and ordering check on the incoming observe value
    always_comb begin
        lt_next       = '0;
        unsorted_next = 1'b0;
        for (int i = 0; i < MAX_BOUNDS; i++) begin
            lt_next[i] = (i < int'(n_i)) && (bound_reg[i] < s_value);
        end
        for (int i = 0; i + 1 < MAX_BOUNDS; i++) begin
            if ((i + 1 < int'(n_i)) && (bound_reg[i] >= bound_reg[i+1])) begin
                unsorted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_bound && (int'(s_slot) < MAX_BOUNDS)) begin
            bound_reg[BND_AW'(s_slot)] <= s_value;
        end
        if (cmd_i.capture) begin
            val_reg      <= s_value;
            lt_reg       <= lt_next;
            unsorted_reg <= unsorted_next;
        end
        if (cmd_i.cnt_idx) begin
            bucket_reg <= IDX_W'($countones(lt_reg));
        end
    end

    assign rd_addr = cmd_i.rd_snap ? snap_idx_reg : bucket_reg;
    assign rd_eff  = rd_vld_reg ? rd_data_reg : '0;
    assign cnt_inc = (&rd_eff) ? rd_eff : rd_eff + COUNT_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd_i.cnt_wr) begin
            cnt_mem[bucket_reg] <= cnt_inc;
        end
        if (cmd_i.rd_obs || cmd_i.rd_snap) begin
            rd_data_reg <= cnt_mem[rd_addr];
            rd_vld_reg  <= cnt_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
        end else if (cmd_i.cnt_wr) begin
            cnt_vld_reg[bucket_reg] <= 1'b1;
        end
    end

    // saturating running sum
    assign sum_add = SUM_W'(val_reg);
    assign sum_raw = sum_reg + sum_add;
    assign sum_ovf = (sum_reg[SUM_W-1] == sum_add[SUM_W-1])
                     && (sum_raw[SUM_W-1] != sum_reg[SUM_W-1]);
    assign sum_sat = sum_ovf ? (sum_add[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cmd_i.cnt_wr) begin
            sum_reg <= sum_sat;
        end
    end

    // snapshot walk
    assign cum_sum  = {1'b0, cum_reg} + {1'b0, rd_eff};
    assign cum_next = cum_sum[COUNT_W] ? '1 : cum_sum[COUNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_idx_reg <= '0;
        end else if (cmd_i.snap_init) begin
            snap_idx_reg <= '0;
        end else if (cmd_i.snap_step) begin
            snap_idx_reg <= snap_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.snap_init) begin
            cum_reg <= '0;
        end else if (cmd_i.snap_step) begin
            cum_reg <= cum_next;
        end
    end

    assign sts_o.unsorted      = unsorted_reg;
    assign sts_o.snap_in_range = (snap_idx_reg < n_i);
    assign sts_o.snap_at_end   = (snap_idx_reg == IDX_W'(MAX_BOUNDS));

    // output register
    always_ff @(posedge aclk) begin
        unique case (cmd_i.emit)
            EMIT_OBS_OK: begin
                m_status       <= 1'b0;
                m_bucket_index <= bucket_reg;
                m_cum_count    <= '0;
                m_bucket_bound <= '0;
                m_is_infinite  <= 1'b0;
                m_total_sum    <= '0;
                m_last         <= 1'b1;
            end
            EMIT_OBS_ERR: begin
                m_status       <= 1'b1;
                m_bucket_index <= '0;
                m_cum_count    <= '0;
                m_bucket_bound <= '0;
                m_is_infinite  <= 1'b0;
                m_total_sum    <= '0;
                m_last         <= 1'b1;
            end
            EMIT_SNAP_MID: begin
                m_status       <= 1'b0;
                m_bucket_index <= snap_idx_reg;
                m_cum_count    <= cum_next;
                m_bucket_bound <= bound_reg[BND_AW'(snap_idx_reg)];
                m_is_infinite  <= 1'b0;
                m_total_sum    <= '0;
                m_last         <= 1'b0;
            end
            EMIT_SNAP_LAST: begin
                m_status       <= 1'b0;
                m_bucket_index <= n_i;
                m_cum_count    <= cum_next;
                m_bucket_bound <= '0;
                m_is_infinite  <= 1'b1;
                m_total_sum    <= sum_reg;
                m_last         <= 1'b1;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/cumulative_bucket_histogram_core.sv @@
// Top level of the cumulative bucket histogram: APB register, controller, datapath.
//
// Cumulative bucket histogram. Input beats carry a kind: load writes one
// signed boundary word into a slot (no result), observe finds the bucket of
// a signed fixed-point value (number of in-use boundaries strictly below it),
// bumps that bucket's 64-bit count and adds the value to a saturating 64-bit
// sum, and snapshot streams the cumulative count of every bounded bucket
// followed by the top bucket, which carries the sum and has m_last set.
// An observe against boundaries that are not strictly increasing returns
// status 1 and changes nothing. The in-use boundary count is an APB register
// at offset 0; it must only be written while the block is idle. Boundaries
// that are in use must be loaded before an observe or snapshot. A load or an
// unused kind is handled in the accept step alone; an observe steps through
// accept, bucket count, count memory read and write back, and a rejected one
// ends at the read step without a read or write back. A snapshot runs a
// read-then-accumulate walk over the single-port count memory, which visits
// every bucket including the ones above the in-use count. A stalled output holds the controller in its emitting step.
// One item is worked on at a time; the next beat is accepted while the last
// result still waits in the output register. Counts are cleared by reset
// through per-bucket valid bits, so no clearing pass is needed.
module cumulative_bucket_histogram_core #(
    parameter int MAX_BOUNDS  = cbh_pkg::MAX_BOUNDS_DEF,
    parameter int VALUE_WIDTH = cbh_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // APB configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cbh_pkg::PADDR_W-1:0]            paddr,
    input  logic [cbh_pkg::PDATA_W-1:0]            pwdata,
    output logic [cbh_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready,
    // input beats
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [cbh_pkg::KIND_W-1:0]             s_kind,
    input  logic [cbh_pkg::SLOT_W-1:0]             s_slot,
    input  logic signed [VALUE_WIDTH-1:0]          s_value,
    // result beats
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_status,
    output logic [$clog2(MAX_BOUNDS+1)-1:0]        m_bucket_index,
    output logic [cbh_pkg::COUNT_W-1:0]            m_cum_count,
    output logic signed [VALUE_WIDTH-1:0]          m_bucket_bound,
    output logic                                   m_is_infinite,
    output logic signed [cbh_pkg::SUM_W-1:0]       m_total_sum,
    output logic                                   m_last
);
    import cbh_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOUNDS + 1);
    // register is at least as wide as the configured field, wider if needed
    localparam int BIU_W = (IDX_W > CFG_BIU_W) ? IDX_W : CFG_BIU_W;

    logic [BIU_W-1:0] bounds_reg;
    logic [IDX_W-1:0] n_active;
    logic             reg_sel;
    logic             cfg_wr;
    cmd_t             cmd;
    sts_t             sts;

    // APB: zero wait states, register written on the access phase
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_BOUNDS_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? PDATA_W'(bounds_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg <= '0;
        end else if (cfg_wr) begin
            bounds_reg <= pwdata[BIU_W-1:0];
        end
    end

    // counts above the bank size act as a full bank
    assign n_active = (bounds_reg > BIU_W'(MAX_BOUNDS)) ? IDX_W'(MAX_BOUNDS)
                                                        : IDX_W'(bounds_reg);

    cbh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts_i   (sts),
        .cmd_o   (cmd)
    );

    cbh_datapath #(
        .MAX_BOUNDS  (MAX_BOUNDS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .n_i            (n_active),
        .s_slot         (s_slot),
        .s_value        (s_value),
        .cmd_i          (cmd),
        .sts_o          (sts),
        .m_status       (m_status),
        .m_bucket_index (m_bucket_index),
        .m_cum_count    (m_cum_count),
        .m_bucket_bound (m_bucket_bound),
        .m_is_infinite  (m_is_infinite),
        .m_total_sum    (m_total_sum),
        .m_last         (m_last)
    );

endmodule
